// File: design/bbms_pkg.sv
// Shared types, constants and helpers for the bouncing ball motion step.
// Used by the control store, the datapath and the top level; no dependencies.
`default_nettype none
package bbms_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 24;
  localparam int WIDE_W    = WORD_W + 3;
  localparam int ANG_W     = 25;
  localparam int UREG_W    = 23;
  localparam int TS_W      = 17;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int ELAPSED_W = 16;
  localparam int DT_W      = 12;
  localparam int SDT_W     = 13;
  localparam int MUL_A_W   = WORD_W + 1;
  localparam int MUL_P_W   = MUL_A_W + TS_W + 1;
  localparam int PROD_W    = 26;
  localparam int STEP_W    = 4;

  localparam logic [DT_W-1:0]            DT_MAX    = DT_W'(3277);
  localparam logic signed [ANG_W:0]      FULL_TURN = (ANG_W+1)'(23592960);
  localparam logic signed [WORD_W-1:0]   WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0]   WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0]   VX_START  = WORD_W'(52429);
  localparam logic signed [WORD_W-1:0]   VY_START  = WORD_W'(294912);

  localparam logic [UREG_W-1:0]        WALL_X_RST  = UREG_W'(96514);
  localparam logic [UREG_W-1:0]        WALL_Z_RST  = UREG_W'(96514);
  localparam logic signed [WORD_W-1:0] FLOOR_Y_RST = -WORD_W'(54292);
  localparam logic [UREG_W-1:0]        RADIUS_RST  = UREG_W'(16384);
  localparam logic signed [WORD_W-1:0] GRAVITY_RST = -WORD_W'(642253);
  localparam logic [UREG_W-1:0]        SPIN_RST    = UREG_W'(7864320);
  localparam logic [UREG_W-1:0]        BOUNCE_RST  = UREG_W'(294912);
  localparam logic [TS_W-1:0]          TSCALE_RST  = TS_W'(32768);

  // Program addresses of the control store
  localparam logic [STEP_W-1:0] STEP_SCALE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_SDT     = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_SPIN    = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_ANGLE   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_VELY    = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_POSX    = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_POSY    = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_POSZ    = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_DEPTH   = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_DONE    = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_RESTART = STEP_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_X  = 3'd0,
    REG_WALL_Z  = 3'd1,
    REG_FLOOR_Y = 3'd2,
    REG_RADIUS  = 3'd3,
    REG_GRAVITY = 3'd4,
    REG_SPIN    = 3'd5,
    REG_BOUNCE  = 3'd6,
    REG_TSCALE  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MA_DT   = 3'd0,
    MA_SPIN = 3'd1,
    MA_GRAV = 3'd2,
    MA_VX   = 3'd3,
    MA_VY   = 3'd4,
    MA_VZ   = 3'd5
  } mul_a_e;

  typedef enum logic {
    MB_TSCALE = 1'b0,
    MB_SDT    = 1'b1
  } mul_b_e;

  typedef enum logic [2:0] {
    WB_NONE  = 3'd0,
    WB_SDT   = 3'd1,
    WB_ANGLE = 3'd2,
    WB_VELY  = 3'd3,
    WB_POSX  = 3'd4,
    WB_POSY  = 3'd5,
    WB_POSZ  = 3'd6
  } wb_e;

  typedef enum logic [1:0] {
    JMP_NEXT    = 2'd0,
    JMP_RESTART = 2'd1,
    JMP_ALWAYS  = 2'd2
  } jmp_e;

  typedef struct packed {
    mul_a_e              mul_a;
    mul_b_e              mul_b;
    wb_e                 wb;
    logic                wrap;
    logic                clamp_y;
    logic                clamp_x;
    logic                clamp_z;
    logic                place;
    logic                clr_hits;
    logic                done;
    jmp_e                jmp;
    logic [STEP_W-1:0]   target;
  } cw_t;

  localparam cw_t CW_IDLE = '{
    mul_a: MA_DT, mul_b: MB_TSCALE, wb: WB_NONE, wrap: 1'b0, clamp_y: 1'b0,
    clamp_x: 1'b0, clamp_z: 1'b0, place: 1'b0, clr_hits: 1'b0, done: 1'b0,
    jmp: JMP_NEXT, target: STEP_SCALE
  };

  typedef struct packed {
    logic                 valid;
    cfg_reg_e             index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic [ANG_W-1:0]         angle;
    logic                     spin_negative;
    logic                     floor_hit;
    logic                     side_hit;
  } res_t;

  // Add and saturate to the signed word range
  function automatic logic signed [WORD_W-1:0] sat_add(
    input logic signed [WORD_W-1:0] a,
    input logic signed [PROD_W-1:0] b
  );
    logic signed [WIDE_W-1:0] s;
    s = WIDE_W'(a) + WIDE_W'(b);
    if (s > WIDE_W'(WORD_MAX)) begin
      return WORD_MAX;
    end else if (s < WIDE_W'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return s[WORD_W-1:0];
  endfunction

  // Magnitude, with the most negative word held at the largest positive one
  function automatic logic signed [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
    if (v == WORD_MIN) begin
      return WORD_MAX;
    end else if (v < 0) begin
      return -v;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/bbms_ucode_rom.sv
// Control store of the motion step: one control word per program address.
// Depends on bbms_pkg for the control word layout and the program addresses.
`default_nettype none
module bbms_ucode_rom (
  input  logic [bbms_pkg::STEP_W-1:0] step_i,
  output bbms_pkg::cw_t               cw_o
);
  import bbms_pkg::*;

  always_comb begin
    cw_o = CW_IDLE;
    unique case (step_i)
      STEP_SCALE: begin
        cw_o.mul_a    = MA_DT;
        cw_o.mul_b    = MB_TSCALE;
        cw_o.clr_hits = 1'b1;
        cw_o.jmp      = JMP_RESTART;
        cw_o.target   = STEP_RESTART;
      end
      STEP_SDT: begin
        cw_o.wb = WB_SDT;
      end
      STEP_SPIN: begin
        cw_o.mul_a = MA_SPIN;
        cw_o.mul_b = MB_SDT;
      end
      STEP_ANGLE: begin
        cw_o.wb    = WB_ANGLE;
        cw_o.mul_a = MA_GRAV;
        cw_o.mul_b = MB_SDT;
      end
      STEP_VELY: begin
        cw_o.wrap  = 1'b1;
        cw_o.wb    = WB_VELY;
        cw_o.mul_a = MA_VX;
        cw_o.mul_b = MB_SDT;
      end
      STEP_POSX: begin
        // vel_y was updated on the previous edge
        cw_o.wb    = WB_POSX;
        cw_o.mul_a = MA_VY;
        cw_o.mul_b = MB_SDT;
      end
      STEP_POSY: begin
        cw_o.wb    = WB_POSY;
        cw_o.mul_a = MA_VZ;
        cw_o.mul_b = MB_SDT;
      end
      STEP_POSZ: begin
        cw_o.wb      = WB_POSZ;
        cw_o.clamp_y = 1'b1;
        cw_o.clamp_x = 1'b1;
      end
      STEP_DEPTH: begin
        cw_o.clamp_z = 1'b1;
      end
      STEP_DONE: begin
        cw_o.done = 1'b1;
      end
      STEP_RESTART: begin
        cw_o.place  = 1'b1;
        cw_o.jmp    = JMP_ALWAYS;
        cw_o.target = STEP_DONE;
      end
      default: begin
        cw_o.done = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/bbms_datapath.sv
// Datapath of the motion step: registers, ball state, one shared multiplier.
// Driven by control words from bbms_ucode_rom; depends on bbms_pkg.
`default_nettype none
module bbms_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  bbms_pkg::cw_t                  cw_i,
  input  logic                           load_i,
  input  logic [bbms_pkg::ELAPSED_W-1:0] elapsed_i,
  input  bbms_pkg::cfg_wr_t              cfg_i,
  output bbms_pkg::res_t                 res_o
);
  import bbms_pkg::*;

  logic [UREG_W-1:0]        wall_x_q, wall_z_q, radius_q, spin_q, bounce_q;
  logic signed [WORD_W-1:0] floor_y_q, gravity_q;
  logic [TS_W-1:0]          tscale_q;

  logic [DT_W-1:0]          dt_q;
  logic [SDT_W-1:0]         sdt_q, sdt_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ANG_W:0]    angle_q, angle_d;
  logic signed [WORD_W-1:0] ball_x_q, ball_x_d, ball_y_q, ball_y_d, ball_z_q, ball_z_d;
  logic signed [WORD_W-1:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d, vel_z_q, vel_z_d;
  logic                     spin_neg_q, spin_neg_d;
  logic                     floor_hit_q, floor_hit_d, side_hit_q, side_hit_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [TS_W-1:0]           mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [WORD_W-1:0]  floor_lim, x_hi, x_lo, z_hi, z_lo;

  // Shared multiplier; the product is taken back by FRAC_BITS (floor)
  always_comb begin
    case (cw_i.mul_a)
      MA_DT:   mul_a = $signed(MUL_A_W'(dt_q));
      MA_SPIN: mul_a = $signed(MUL_A_W'(spin_q));
      MA_GRAV: mul_a = MUL_A_W'(gravity_q);
      MA_VX:   mul_a = MUL_A_W'(vel_x_q);
      MA_VY:   mul_a = MUL_A_W'(vel_y_q);
      MA_VZ:   mul_a = MUL_A_W'(vel_z_q);
      default: mul_a = '0;
    endcase
    mul_b = (cw_i.mul_b == MB_SDT) ? TS_W'(sdt_q) : tscale_q;
    mul_p = mul_a * $signed({1'b0, mul_b});
    prod_d = mul_p[FRAC_BITS +: PROD_W];
  end

  assign floor_lim = sat_add(floor_y_q, $signed(PROD_W'(radius_q)));
  assign x_hi = $signed({1'b0, wall_x_q}) - $signed({1'b0, radius_q});
  assign x_lo = $signed({1'b0, radius_q}) - $signed({1'b0, wall_x_q});
  assign z_hi = $signed({1'b0, wall_z_q}) - $signed({1'b0, radius_q});
  assign z_lo = $signed({1'b0, radius_q}) - $signed({1'b0, wall_z_q});

  always_comb begin
    sdt_d       = sdt_q;
    angle_d     = angle_q;
    ball_x_d    = ball_x_q;
    ball_y_d    = ball_y_q;
    ball_z_d    = ball_z_q;
    vel_x_d     = vel_x_q;
    vel_y_d     = vel_y_q;
    vel_z_d     = vel_z_q;
    spin_neg_d  = spin_neg_q;
    floor_hit_d = floor_hit_q;
    side_hit_d  = side_hit_q;

    case (cw_i.wb)
      WB_SDT:   sdt_d = prod_q[SDT_W-1:0];
      WB_ANGLE: angle_d = spin_neg_q ? angle_q - prod_q : angle_q + prod_q;
      WB_VELY:  vel_y_d = sat_add(vel_y_q, prod_q);
      WB_POSX:  ball_x_d = sat_add(ball_x_q, prod_q);
      WB_POSY:  ball_y_d = sat_add(ball_y_q, prod_q);
      WB_POSZ:  ball_z_d = sat_add(ball_z_q, prod_q);
      default: ;
    endcase

    // Bring the angle back into 0..360 once; exactly 360 stays
    if (cw_i.wrap) begin
      if (angle_q > FULL_TURN) begin
        angle_d = angle_q - FULL_TURN;
      end else if (angle_q < 0) begin
        angle_d = angle_q + FULL_TURN;
      end
    end

    if (cw_i.clr_hits) begin
      floor_hit_d = 1'b0;
      side_hit_d  = 1'b0;
    end

    if (cw_i.clamp_y && (ball_y_q < floor_lim)) begin
      ball_y_d    = floor_lim;
      vel_y_d     = $signed({1'b0, bounce_q});
      floor_hit_d = 1'b1;
    end

    // Upper wall is tested first and wins in an inverted room
    if (cw_i.clamp_x) begin
      if (ball_x_q > x_hi) begin
        ball_x_d   = x_hi;
        vel_x_d    = -mag(vel_x_q);
        spin_neg_d = ~spin_neg_q;
        side_hit_d = 1'b1;
      end else if (ball_x_q < x_lo) begin
        ball_x_d   = x_lo;
        vel_x_d    = mag(vel_x_q);
        spin_neg_d = ~spin_neg_q;
        side_hit_d = 1'b1;
      end
    end

    if (cw_i.clamp_z) begin
      if (ball_z_q > z_hi) begin
        ball_z_d = z_hi;
        vel_z_d  = -mag(vel_z_q);
      end else if (ball_z_q < z_lo) begin
        ball_z_d = z_lo;
        vel_z_d  = mag(vel_z_q);
      end
    end

    if (cw_i.place) begin
      ball_x_d = x_lo;
      ball_y_d = floor_lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_x_q  <= WALL_X_RST;
      wall_z_q  <= WALL_Z_RST;
      floor_y_q <= FLOOR_Y_RST;
      radius_q  <= RADIUS_RST;
      gravity_q <= GRAVITY_RST;
      spin_q    <= SPIN_RST;
      bounce_q  <= BOUNCE_RST;
      tscale_q  <= TSCALE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WALL_X:  wall_x_q  <= cfg_i.data[UREG_W-1:0];
        REG_WALL_Z:  wall_z_q  <= cfg_i.data[UREG_W-1:0];
        REG_FLOOR_Y: floor_y_q <= $signed(cfg_i.data[WORD_W-1:0]);
        REG_RADIUS:  radius_q  <= cfg_i.data[UREG_W-1:0];
        REG_GRAVITY: gravity_q <= $signed(cfg_i.data[WORD_W-1:0]);
        REG_SPIN:    spin_q    <= cfg_i.data[UREG_W-1:0];
        REG_BOUNCE:  bounce_q  <= cfg_i.data[UREG_W-1:0];
        REG_TSCALE:  tscale_q  <= cfg_i.data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_x_q    <= '0;
      ball_y_q    <= '0;
      ball_z_q    <= '0;
      vel_x_q     <= VX_START;
      vel_y_q     <= VY_START;
      vel_z_q     <= '0;
      angle_q     <= '0;
      spin_neg_q  <= 1'b0;
      floor_hit_q <= 1'b0;
      side_hit_q  <= 1'b0;
    end else if (en_i) begin
      ball_x_q    <= ball_x_d;
      ball_y_q    <= ball_y_d;
      ball_z_q    <= ball_z_d;
      vel_x_q     <= vel_x_d;
      vel_y_q     <= vel_y_d;
      vel_z_q     <= vel_z_d;
      angle_q     <= angle_d;
      spin_neg_q  <= spin_neg_d;
      floor_hit_q <= floor_hit_d;
      side_hit_q  <= side_hit_d;
    end
  end

  // Working registers carry no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dt_q <= (elapsed_i > ELAPSED_W'(DT_MAX)) ? DT_MAX : elapsed_i[DT_W-1:0];
    end
    if (en_i) begin
      prod_q <= prod_d;
      sdt_q  <= sdt_d;
    end
  end

  assign res_o.pos_x         = ball_x_q;
  assign res_o.pos_y         = ball_y_q;
  assign res_o.pos_z         = ball_z_q;
  assign res_o.angle         = angle_q[ANG_W-1:0];
  assign res_o.spin_negative = spin_neg_q;
  assign res_o.floor_hit     = floor_hit_q;
  assign res_o.side_hit      = side_hit_q;

endmodule
`default_nettype wire

// File: design/bouncing_ball_motion_step.sv
// Top level of the bouncing ball motion step: sequencer, handshakes, result register.
// Instantiates bbms_ucode_rom and bbms_datapath; depends on bbms_pkg.
//
//   channel  direction  signals                                    transfer when
//   in       input      in_valid_i, in_stall_o, action_i, elapsed_i  valid and not stall
//   out      output     out_valid_o, out_stall_i, pos/angle/flags  valid and not stall
//   cfg      input      cfg_valid_i, cfg_ready_o, cfg_index_i,     valid and ready
//                       cfg_data_i
//
// A tick runs every step from SCALE to DONE, a restart SCALE, RESTART and DONE, one
// step of the control program per cycle; one shared multiplier sets the tick length.
// The next item is taken in the cycle its predecessor's result is registered.
// Reset restores the configuration defaults and the starting ball state.
// A stalled output holds the program at its final step until the register frees.
// Configuration writes are held off while an item is being computed.
`default_nettype none
module bouncing_ball_motion_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic [bbms_pkg::ELAPSED_W-1:0]        elapsed_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bbms_pkg::WORD_W-1:0]    pos_x_o,
  output logic signed [bbms_pkg::WORD_W-1:0]    pos_y_o,
  output logic signed [bbms_pkg::WORD_W-1:0]    pos_z_o,
  output logic [bbms_pkg::ANG_W-1:0]            angle_o,
  output logic                                  spin_negative_o,
  output logic                                  floor_hit_o,
  output logic                                  side_hit_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bbms_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bbms_pkg::CFG_W-1:0]            cfg_data_i
);
  import bbms_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              restart_q;
  logic              out_valid_q;
  res_t              res_q;
  res_t              dp_res;
  cw_t               cw;
  cfg_wr_t           cfg_wr;
  logic              in_xfer, fire;

  bbms_ucode_rom u_rom (
    .step_i (step_q),
    .cw_o   (cw)
  );

  assign cfg_ready_o  = !busy_q;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_reg_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  bbms_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (busy_q),
    .cw_i      (cw),
    .load_i    (in_xfer),
    .elapsed_i (elapsed_i),
    .cfg_i     (cfg_wr),
    .res_o     (dp_res)
  );

  // Final step registers the result once the output register is free
  assign fire       = busy_q && cw.done && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (in_xfer) begin
      step_d = STEP_SCALE;
      busy_d = 1'b1;
    end else if (fire) begin
      busy_d = 1'b0;
    end else if (busy_q && !cw.done) begin
      unique case (cw.jmp)
        JMP_NEXT:    step_d = step_q + STEP_W'(1);
        JMP_RESTART: step_d = restart_q ? cw.target : step_q + STEP_W'(1);
        JMP_ALWAYS:  step_d = cw.target;
        default:     step_d = STEP_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_SCALE;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      restart_q <= action_i;
    end
    if (fire) begin
      res_q <= dp_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = res_q.pos_x;
  assign pos_y_o         = res_q.pos_y;
  assign pos_z_o         = res_q.pos_z;
  assign angle_o         = res_q.angle;
  assign spin_negative_o = res_q.spin_negative;
  assign floor_hit_o     = res_q.floor_hit;
  assign side_hit_o      = res_q.side_hit;

`ifndef SYNTHESIS
  a_rise_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && cw.done))
    else $error("result appeared without the final program step");

  a_step_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cw.done && (cw.jmp == JMP_NEXT) && !in_xfer |=>
      step_q == $past(step_q) + STEP_W'(1))
    else $error("program counter did not advance");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cw.done |-> ({1'b0, dp_res.angle} <= FULL_TURN))
    else $error("spin angle out of range at result time");

  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= STEP_RESTART)
    else $error("program counter past the end of the program");
`endif

endmodule
`default_nettype wire

// File: bench/bouncing_ball_motion_step_test.sv
`timescale 1ns / 1ps
// Self-checking bench for bouncing_ball_motion_step: queued ticks and restarts, random
// handshake gaps, room settings swept between phases. Needs only bbms_pkg and the block.
module bouncing_ball_motion_step_test;
  import bbms_pkg::*;

  localparam int     IDLE_PCT    = 14;
  localparam int     CYCLE_LIMIT = 400000;
  localparam longint DT_CAP      = 3277;
  localparam longint TURN_FX     = 64'd360 << FRAC_BITS;
  localparam longint SAT_HI      = (64'sd1 <<< (WORD_W - 1)) - 1;
  localparam longint SAT_LO      = -(64'sd1 <<< (WORD_W - 1));

  typedef struct {
    logic                 restart;
    logic [ELAPSED_W-1:0] elapsed;
  } move_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 action_i    = 1'b0;
  logic [ELAPSED_W-1:0] elapsed_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [WORD_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [ANG_W-1:0]     angle_o;
  logic                 spin_negative_o, floor_hit_o, side_hit_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  // Room settings as the block holds them
  logic [UREG_W-1:0]        room_half_x, room_half_z, radius_r, spin_rate, rebound_vel;
  logic signed [WORD_W-1:0] floor_lvl, grav_r;
  logic [TS_W-1:0]          speed_factor;
  // Ball state
  logic signed [WORD_W-1:0] ball_px, ball_py, ball_pz, ball_vx, ball_vy, ball_vz;
  logic [ANG_W-1:0]         spin_deg;
  logic                     spin_rev;

  move_t  pending_moves[$];
  res_t   predicted_poses[$];
  move_t  next_move;
  res_t   next_pose;
  int     mismatches = 0;
  int     moves_sent = 0;
  int     cycles     = 0;
  int     hold_left  = 0;
  bit     held_once  = 1'b0;
  bit     calm       = 1'b0;

  bouncing_ball_motion_step DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .action_i(action_i), .elapsed_i(elapsed_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .pos_z_o(pos_z_o), .angle_o(angle_o),
    .spin_negative_o(spin_negative_o), .floor_hit_o(floor_hit_o), .side_hit_o(side_hit_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clip_word(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Floor of a*b / 2^FRAC_BITS
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint abs_word(longint v);
    return clip_word(v < 0 ? -v : v);
  endfunction

  function automatic void reset_room();
    room_half_x  = 23'd96514;
    room_half_z  = 23'd96514;
    floor_lvl    = -24'sd54292;
    radius_r     = 23'd16384;
    grav_r       = -24'sd642253;
    spin_rate    = 23'd7864320;
    rebound_vel  = 23'd294912;
    speed_factor = 17'd32768;
    ball_px      = '0;
    ball_py      = '0;
    ball_pz      = '0;
    ball_vx      = 24'sd52429;
    ball_vy      = 24'sd294912;
    ball_vz      = '0;
    spin_deg     = '0;
    spin_rev     = 1'b0;
  endfunction

  function automatic void load_reg(cfg_reg_e idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_WALL_X:  room_half_x  = d[UREG_W-1:0];
      REG_WALL_Z:  room_half_z  = d[UREG_W-1:0];
      REG_FLOOR_Y: floor_lvl    = d;
      REG_RADIUS:  radius_r     = d[UREG_W-1:0];
      REG_GRAVITY: grav_r       = d;
      REG_SPIN:    spin_rate    = d[UREG_W-1:0];
      REG_BOUNCE:  rebound_vel  = d[UREG_W-1:0];
      REG_TSCALE:  speed_factor = d[TS_W-1:0];
      default: ;
    endcase
  endfunction

  // One Euler step of the ball, or a restart; returns the pose the block must report
  function automatic res_t advance_ball(logic restart, logic [ELAPSED_W-1:0] elapsed);
    longint dt, sdt, turn, hi, lo;
    res_t r;
    r.floor_hit = 1'b0;
    r.side_hit  = 1'b0;
    if (restart) begin
      ball_px = WORD_W'(clip_word(longint'(radius_r) - longint'(room_half_x)));
      ball_py = WORD_W'(clip_word(longint'(floor_lvl) + longint'(radius_r)));
    end else begin
      dt   = (longint'(elapsed) > DT_CAP) ? DT_CAP : longint'(elapsed);
      sdt  = fx_mul(dt, longint'(speed_factor));
      turn = fx_mul(longint'(spin_rate), sdt);
      turn = spin_rev ? longint'(spin_deg) - turn : longint'(spin_deg) + turn;
      // wrap once; exactly a full turn is kept
      if (turn > TURN_FX) turn -= TURN_FX;
      if (turn < 0) turn += TURN_FX;
      spin_deg = ANG_W'(turn);

      ball_vy = WORD_W'(clip_word(longint'(ball_vy) + fx_mul(longint'(grav_r), sdt)));
      ball_px = WORD_W'(clip_word(longint'(ball_px) + fx_mul(longint'(ball_vx), sdt)));
      ball_py = WORD_W'(clip_word(longint'(ball_py) + fx_mul(longint'(ball_vy), sdt)));
      ball_pz = WORD_W'(clip_word(longint'(ball_pz) + fx_mul(longint'(ball_vz), sdt)));

      lo = clip_word(longint'(floor_lvl) + longint'(radius_r));
      if (longint'(ball_py) < lo) begin
        ball_py     = WORD_W'(lo);
        ball_vy     = WORD_W'(clip_word(longint'(rebound_vel)));
        r.floor_hit = 1'b1;
      end

      hi = clip_word(longint'(room_half_x) - longint'(radius_r));
      lo = clip_word(longint'(radius_r) - longint'(room_half_x));
      if (longint'(ball_px) > hi) begin
        ball_px    = WORD_W'(hi);
        ball_vx    = WORD_W'(-abs_word(longint'(ball_vx)));
        spin_rev   = ~spin_rev;
        r.side_hit = 1'b1;
      end else if (longint'(ball_px) < lo) begin
        ball_px    = WORD_W'(lo);
        ball_vx    = WORD_W'(abs_word(longint'(ball_vx)));
        spin_rev   = ~spin_rev;
        r.side_hit = 1'b1;
      end

      hi = clip_word(longint'(room_half_z) - longint'(radius_r));
      lo = clip_word(longint'(radius_r) - longint'(room_half_z));
      if (longint'(ball_pz) > hi) begin
        ball_pz = WORD_W'(hi);
        ball_vz = WORD_W'(-abs_word(longint'(ball_vz)));
      end else if (longint'(ball_pz) < lo) begin
        ball_pz = WORD_W'(lo);
        ball_vz = WORD_W'(abs_word(longint'(ball_vz)));
      end
    end
    r.pos_x         = ball_px;
    r.pos_y         = ball_py;
    r.pos_z         = ball_pz;
    r.angle         = spin_deg;
    r.spin_negative = spin_rev;
    return r;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic move_t random_move();
    move_t m;
    m.restart = ($urandom_range(99) < 8);
    case ($urandom_range(2))
      0:       m.elapsed = ELAPSED_W'($urandom_range(16'hFFFF));
      1:       m.elapsed = ELAPSED_W'($urandom_range(3400, 3150));
      default: m.elapsed = ELAPSED_W'($urandom_range(3277));
    endcase
    return m;
  endfunction

  task automatic queue_move(logic restart, logic [ELAPSED_W-1:0] elapsed);
    move_t m;
    m.restart = restart;
    m.elapsed = elapsed;
    pending_moves.push_back(m);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_moves.push_back(random_move());
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    load_reg(idx, d);
  endtask

  task automatic set_room(logic [CFG_W-1:0] wx, wz, fy, rr, gv, sp, bo, ts);
    write_reg(REG_WALL_X, wx);
    write_reg(REG_WALL_Z, wz);
    write_reg(REG_FLOOR_Y, fy);
    write_reg(REG_RADIUS, rr);
    write_reg(REG_GRAVITY, gv);
    write_reg(REG_SPIN, sp);
    write_reg(REG_BOUNCE, bo);
    write_reg(REG_TSCALE, ts);
  endtask

  // Hold until every queued move has been taken and every pose has come back
  task automatic wait_idle();
    while (pending_moves.size() != 0 || in_valid_i || predicted_poses.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Input side: offer queued moves, hold a stalled transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i   <= 1'b0;
      elapsed_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_poses.push_back(advance_ball(action_i, elapsed_i));
        moves_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_moves.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_move = pending_moves.pop_front();
          in_valid_i <= 1'b1;
          action_i   <= next_move.restart;
          elapsed_i  <= next_move.elapsed;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!held_once && moves_sent >= 300) begin
      held_once   <= 1'b1;
      hold_left   <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_poses.size() == 0) begin
        $display("%0t: pose with none pending, expected none, actual x %0d y %0d z %0d",
                 $time, pos_x_o, pos_y_o, pos_z_o);
        mismatches++;
      end else begin
        next_pose = predicted_poses.pop_front();
        check_field("pos_x", next_pose.pos_x, pos_x_o);
        check_field("pos_y", next_pose.pos_y, pos_y_o);
        check_field("pos_z", next_pose.pos_z, pos_z_o);
        check_field("angle", next_pose.angle, angle_o);
        check_field("spin_negative", next_pose.spin_negative, spin_negative_o);
        check_field("floor_hit", next_pose.floor_hit, floor_hit_o);
        check_field("side_hit", next_pose.side_hit, side_hit_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d poses still pending", $time, predicted_poses.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reset_room();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the spin up to exactly a full turn: 32 steps of 737280 from zero
    write_reg(REG_WALL_X, 24'h7FFFFF);
    write_reg(REG_TSCALE, 24'd122873);
    for (int i = 0; i < 34; i++) queue_move(1'b0, ELAPSED_W'($urandom_range(16'hFFFF, 3277)));
    wait_idle();

    // Elapsed extremes and the clamp edge in the default room
    set_room(24'd96514, 24'd96514, 24'(-54292), 24'd16384, 24'(-642253), 24'd7864320,
             24'd294912, 24'd32768);
    queue_move(1'b1, 16'h0000);
    queue_move(1'b0, 16'h0000);
    queue_move(1'b0, 16'h0001);
    queue_move(1'b0, 16'd3276);
    queue_move(1'b0, 16'd3277);
    queue_move(1'b0, 16'd3278);
    queue_move(1'b0, 16'hFFFF);
    queue_move(1'b0, 16'h5555);
    queue_move(1'b0, 16'hAAAA);
    queue_move(1'b1, 16'hFFFF);
    wait_idle();

    // Inverted room, saturating floor and gravity, oversized writes masked
    set_room(24'h000000, 24'h000000, 24'h7FFFFF, 24'hFFFFFF, 24'h800000, 24'hFFFFFF,
             24'hFFFFFF, 24'hFFFFFF);
    queue_move(1'b0, 16'hFFFF);
    queue_move(1'b0, 16'h0000);
    queue_move(1'b1, 16'h1234);
    queue_move(1'b0, 16'd3277);
    queue_move(1'b0, 16'd3277);
    queue_move(1'b0, 16'h8000);
    wait_idle();
    write_reg(REG_TSCALE, 24'h000000);
    queue_move(1'b0, 16'hFFFF);
    queue_move(1'b1, 16'h0000);
    wait_idle();

    // Fast playback, default room but top spin and time scale, no gaps on either side
    calm = 1'b1;
    set_room(24'd96514, 24'd96514, 24'(-54292), 24'd16384, 24'(-642253), 24'h7FFFFF,
             24'd294912, 24'h1FFFF);
    queue_random(150);
    wait_idle();
    calm = 1'b0;

    // Narrow room, strongest gravity, frequent bounces and wall hits
    set_room(24'd20000, 24'd30000, 24'(-200000), 24'd16384, 24'h800000, 24'd0,
             24'h7FFFFF, 24'd65536);
    queue_random(150);
    wait_idle();

    // Widest in x, flat in z, lowest floor, upward gravity drives y into saturation
    set_room(24'hFFFFFF, 24'd0, 24'h800000, 24'd0, 24'h7FFFFF, 24'd1, 24'd0, 24'h1FFFF);
    queue_random(150);
    wait_idle();

    repeat (3) begin
      set_room($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
      queue_random(100);
      wait_idle();
    end

    set_room(24'd96514, 24'd96514, 24'(-54292), 24'd16384, 24'(-642253), 24'd7864320,
             24'd294912, 24'd32768);
    queue_random(150);
    wait_idle();

    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
